/* rtl/rlbf_pkg.sv */
package rlbf_pkg;

   // stored op kinds
   typedef enum logic [2:0] {
      K_INC   = 3'd0,
      K_DEC   = 3'd1,
      K_RIGHT = 3'd2,
      K_LEFT  = 3'd3,
      K_WRITE = 3'd4,
      K_READ  = 3'd5,
      K_OPEN  = 3'd6,
      K_CLOSE = 3'd7
   } op_kind_type;

   // result status codes
   localparam logic [2:0] ST_LOADED   = 3'd0;
   localparam logic [2:0] ST_EXECUTED = 3'd1;
   localparam logic [2:0] ST_WROTE    = 3'd2;
   localparam logic [2:0] ST_READ     = 3'd3;
   localparam logic [2:0] ST_HALTED   = 3'd4;
   localparam logic [2:0] ST_UNMATCH  = 3'd5;
   localparam logic [2:0] ST_OVERFLOW = 3'd6;

   localparam logic REQ_APPEND = 1'b0;
   localparam logic REQ_STEP   = 1'b1;

   localparam logic [7:0] MAX_COUNT = 8'd255;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_APPEND,
      S_EXEC,
      S_SCAN_RD,
      S_SCAN,
      S_RESP
   } state_type;

   // source character to op kind; valid flag in bit 3
   function automatic logic [3:0] classify(input logic [7:0] c);
      logic [3:0] r;
      r = 4'd0;
      case (c)
         8'h2B:   r = {1'b1, K_INC};
         8'h2D:   r = {1'b1, K_DEC};
         8'h3E:   r = {1'b1, K_RIGHT};
         8'h3C:   r = {1'b1, K_LEFT};
         8'h2E:   r = {1'b1, K_WRITE};
         8'h2C:   r = {1'b1, K_READ};
         8'h5B:   r = {1'b1, K_OPEN};
         8'h5D:   r = {1'b1, K_CLOSE};
         default: r = 4'd0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/run_length_bf_machine.sv */
// Channel  | Ports                                          | Direction
// request  | req_valid, req_stall, req_opcode,              | in (stall out)
//          | req_source_char, req_in_byte                   |
// response | rsp_valid, rsp_stall, rsp_status,              | out (stall in)
//          | rsp_out_byte, rsp_program_counter              |
//
// An append reads the program store, then writes back.
// During a step, an open bracket on a zero cell scans forward one stored op
// per cycle, examining ops up to and including its match, or up to the end
// of the program when there is none.
// After reset the tape is cleared one cell per cycle, with req_stall high.
// The result sits in an output register; the next request is taken once it
// has left.
module run_length_bf_machine #(
   parameter int PROG_DEPTH  = 4096,
   parameter int TAPE_DEPTH  = 32768,
   parameter int CELL_BITS   = 8,
   parameter int STACK_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [7:0]  req_source_char,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_out_byte,
   output logic [11:0] rsp_program_counter
);

   localparam int PW = $clog2(PROG_DEPTH);
   localparam int TW = $clog2(TAPE_DEPTH);
   localparam int SW = $clog2(STACK_DEPTH);

   // memories
   logic [2:0]           op_mem    [PROG_DEPTH];
   logic [7:0]           cnt_mem   [PROG_DEPTH];
   logic [CELL_BITS-1:0] tape_mem  [TAPE_DEPTH];
   logic [PW-1:0]        stack_mem [STACK_DEPTH];

   rlbf_pkg::state_type state_ff, state_in;

   logic [PW:0]          plen_ff, plen_in;
   logic [PW:0]          pc_ff, pc_in;
   logic [TW-1:0]        dp_ff, dp_in;
   logic [SW:0]          sl_ff, sl_in;
   logic [7:0]           rep_ff, rep_in;
   logic                 halted_ff, halted_in;
   logic [PW:0]          depth_ff, depth_in;
   logic [TW-1:0]        clr_ff, clr_in;
   logic [7:0]           ch_ff, byte_ff;
   logic [2:0]           st_ff, st_in;
   logic [7:0]           ob_ff, ob_in;

   // memory read ports (registered data)
   logic [PW-1:0]        prd_addr;
   logic [2:0]           op_rd_ff;
   logic [7:0]           cnt_rd_ff;
   logic [CELL_BITS-1:0] cell_rd_ff;
   logic [PW-1:0]        stk_rd_ff;

   // write controls
   logic                 pwr_en;
   logic [PW-1:0]        pwr_addr;
   logic [2:0]           pwr_op;
   logic [7:0]           pwr_cnt;
   logic                 twr_en;
   logic [TW-1:0]        twr_addr;
   logic [CELL_BITS-1:0] twr_data;
   logic                 swr_en;

   logic                 accept;
   logic [3:0]           cls;
   logic [PW:0]          last_idx;
   logic [PW:0]          pc_next;
   logic [TW:0]          move_sum;
   logic [7:0]           rep_cur;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != rlbf_pkg::S_IDLE);
   assign rsp_valid = (state_ff == rlbf_pkg::S_RESP);
   assign rsp_status = st_ff;
   assign rsp_out_byte = ob_ff;
   assign rsp_program_counter = 12'(pc_ff);

   assign cls       = rlbf_pkg::classify(ch_ff);
   assign last_idx  = plen_ff - 1'b1;
   assign pc_next   = pc_ff + 1'b1;
   assign rep_cur   = (rep_ff == 8'd0) ? cnt_rd_ff - 8'd1 : rep_ff - 8'd1;

   // program store read address
   always_comb begin
      case (state_ff)
         rlbf_pkg::S_IDLE:    prd_addr = (req_opcode == rlbf_pkg::REQ_APPEND)
                                         ? last_idx[PW-1:0] : pc_ff[PW-1:0];
         rlbf_pkg::S_EXEC:    prd_addr = pc_next[PW-1:0];
         rlbf_pkg::S_SCAN_RD: prd_addr = pc_ff[PW-1:0];
         rlbf_pkg::S_SCAN:    prd_addr = pc_next[PW-1:0] + 1'b1;
         default:             prd_addr = pc_ff[PW-1:0];
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      op_rd_ff   <= op_mem[prd_addr];
      cnt_rd_ff  <= cnt_mem[prd_addr];
      cell_rd_ff <= tape_mem[dp_ff];
      stk_rd_ff  <= stack_mem[sl_ff[SW-1:0] - 1'b1];
      if (pwr_en) begin
         op_mem[pwr_addr]  <= pwr_op;
         cnt_mem[pwr_addr] <= pwr_cnt;
      end
      if (twr_en) begin
         tape_mem[twr_addr] <= twr_data;
      end
      if (swr_en) begin
         stack_mem[sl_ff[SW-1:0]] <= pc_ff[PW-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rlbf_pkg::S_CLEAR:
            if (clr_ff == TW'(TAPE_DEPTH - 1)) state_in = rlbf_pkg::S_IDLE;
         rlbf_pkg::S_IDLE:
            if (accept) begin
               state_in = (req_opcode == rlbf_pkg::REQ_APPEND)
                          ? rlbf_pkg::S_APPEND : rlbf_pkg::S_EXEC;
            end
         rlbf_pkg::S_APPEND: state_in = rlbf_pkg::S_RESP;
         rlbf_pkg::S_EXEC: begin
            state_in = rlbf_pkg::S_RESP;
            if (!halted_ff && pc_ff < plen_ff &&
                op_rd_ff == rlbf_pkg::K_OPEN && cell_rd_ff == '0 &&
                pc_next < plen_ff) begin
               state_in = rlbf_pkg::S_SCAN;
            end
         end
         rlbf_pkg::S_SCAN_RD: state_in = rlbf_pkg::S_SCAN;
         rlbf_pkg::S_SCAN: begin
            if (op_rd_ff == rlbf_pkg::K_CLOSE && depth_ff == (PW+1)'(1)) begin
               state_in = rlbf_pkg::S_RESP;
            end else if (pc_next + 1'b1 >= plen_ff) begin
               state_in = rlbf_pkg::S_RESP;
            end
         end
         rlbf_pkg::S_RESP:
            if (!rsp_stall) state_in = rlbf_pkg::S_IDLE;
         default: state_in = rlbf_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      plen_in   = plen_ff;
      pc_in     = pc_ff;
      dp_in     = dp_ff;
      sl_in     = sl_ff;
      rep_in    = rep_ff;
      halted_in = halted_ff;
      depth_in  = depth_ff;
      clr_in    = clr_ff;
      st_in     = st_ff;
      ob_in     = ob_ff;
      pwr_en    = 1'b0;
      pwr_addr  = plen_ff[PW-1:0];
      pwr_op    = cls[2:0];
      pwr_cnt   = 8'd1;
      twr_en    = 1'b0;
      twr_addr  = dp_ff;
      twr_data  = cell_rd_ff;
      swr_en    = 1'b0;
      move_sum  = '0;
      case (state_ff)
         rlbf_pkg::S_CLEAR: begin
            twr_en   = 1'b1;
            twr_addr = clr_ff;
            twr_data = '0;
            clr_in   = clr_ff + 1'b1;
         end
         rlbf_pkg::S_IDLE: begin
            st_in = rlbf_pkg::ST_LOADED;
            ob_in = 8'd0;
         end
         rlbf_pkg::S_APPEND: begin
            // merge into the last op, else append a new one if there is room
            if (cls[3]) begin
               if (cls[2:0] != rlbf_pkg::K_OPEN && cls[2:0] != rlbf_pkg::K_CLOSE
                   && plen_ff != '0 && op_rd_ff == cls[2:0]
                   && cnt_rd_ff < rlbf_pkg::MAX_COUNT) begin
                  pwr_en   = 1'b1;
                  pwr_addr = last_idx[PW-1:0];
                  pwr_cnt  = cnt_rd_ff + 8'd1;
               end else if (plen_ff >= (PW+1)'(PROG_DEPTH)) begin
                  st_in = rlbf_pkg::ST_OVERFLOW;
               end else begin
                  pwr_en  = 1'b1;
                  plen_in = plen_ff + 1'b1;
               end
            end
         end
         rlbf_pkg::S_EXEC: begin
            if (halted_ff || pc_ff >= plen_ff) begin
               st_in = rlbf_pkg::ST_HALTED;
            end else begin
               st_in = rlbf_pkg::ST_EXECUTED;
               case (op_rd_ff)
                  rlbf_pkg::K_INC: begin
                     twr_en   = 1'b1;
                     twr_data = cell_rd_ff + CELL_BITS'(cnt_rd_ff);
                     pc_in    = pc_next;
                  end
                  rlbf_pkg::K_DEC: begin
                     twr_en   = 1'b1;
                     twr_data = cell_rd_ff - CELL_BITS'(cnt_rd_ff);
                     pc_in    = pc_next;
                  end
                  rlbf_pkg::K_RIGHT: begin
                     move_sum = (TW+1)'(dp_ff) + (TW+1)'(cnt_rd_ff % TAPE_DEPTH);
                     dp_in = (move_sum >= (TW+1)'(TAPE_DEPTH))
                             ? TW'(move_sum - (TW+1)'(TAPE_DEPTH)) : TW'(move_sum);
                     pc_in = pc_next;
                  end
                  rlbf_pkg::K_LEFT: begin
                     move_sum = (TW+1)'(dp_ff) + (TW+1)'(TAPE_DEPTH)
                                - (TW+1)'(cnt_rd_ff % TAPE_DEPTH);
                     dp_in = (move_sum >= (TW+1)'(TAPE_DEPTH))
                             ? TW'(move_sum - (TW+1)'(TAPE_DEPTH)) : TW'(move_sum);
                     pc_in = pc_next;
                  end
                  rlbf_pkg::K_WRITE, rlbf_pkg::K_READ: begin
                     rep_in = rep_cur;
                     if (rep_cur == 8'd0) pc_in = pc_next;
                     if (op_rd_ff == rlbf_pkg::K_WRITE) begin
                        st_in = rlbf_pkg::ST_WROTE;
                        ob_in = 8'(cell_rd_ff);
                     end else begin
                        st_in    = rlbf_pkg::ST_READ;
                        twr_en   = 1'b1;
                        twr_data = CELL_BITS'(byte_ff);
                     end
                  end
                  rlbf_pkg::K_OPEN: begin
                     if (cell_rd_ff != '0) begin
                        if (sl_ff >= (SW+1)'(STACK_DEPTH)) begin
                           halted_in = 1'b1;
                           st_in     = rlbf_pkg::ST_OVERFLOW;
                        end else begin
                           swr_en = 1'b1;
                           sl_in  = sl_ff + 1'b1;
                           pc_in  = pc_next;
                        end
                     end else begin
                        // forward scan: next op already being read
                        depth_in = (PW+1)'(1);
                        if (pc_next >= plen_ff) pc_in = plen_ff;
                     end
                  end
                  default: begin
                     if (sl_ff == '0) begin
                        halted_in = 1'b1;
                        st_in     = rlbf_pkg::ST_UNMATCH;
                     end else if (cell_rd_ff != '0) begin
                        pc_in = (PW+1)'(stk_rd_ff) + 1'b1;
                     end else begin
                        sl_in = sl_ff - 1'b1;
                        pc_in = pc_next;
                     end
                  end
               endcase
            end
         end
         rlbf_pkg::S_SCAN: begin
            // op at pc_next is in op_rd_ff
            pc_in = pc_next;
            if (op_rd_ff == rlbf_pkg::K_OPEN) begin
               depth_in = depth_ff + 1'b1;
            end else if (op_rd_ff == rlbf_pkg::K_CLOSE) begin
               depth_in = depth_ff - 1'b1;
               if (depth_ff == (PW+1)'(1)) pc_in = pc_next + 1'b1;
            end
            if (!(op_rd_ff == rlbf_pkg::K_CLOSE && depth_ff == (PW+1)'(1)) &&
                pc_next + 1'b1 >= plen_ff) begin
               pc_in = plen_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rlbf_pkg::S_CLEAR;
         plen_ff   <= '0;
         pc_ff     <= '0;
         dp_ff     <= '0;
         sl_ff     <= '0;
         rep_ff    <= '0;
         halted_ff <= 1'b0;
         clr_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         plen_ff   <= plen_in;
         pc_ff     <= pc_in;
         dp_ff     <= dp_in;
         sl_ff     <= sl_in;
         rep_ff    <= rep_in;
         halted_ff <= halted_in;
         clr_ff    <= clr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      depth_ff <= depth_in;
      st_ff    <= st_in;
      ob_ff    <= ob_in;
      if (accept) begin
         ch_ff   <= req_source_char;
         byte_ff <= req_in_byte;
      end
   end

endmodule

/* bench/run_length_bf_machine_checker.sv */
`timescale 1ns / 1ps

module run_length_bf_machine_checker #(
   parameter int PROG_DEPTH  = 4096,
   parameter int TAPE_DEPTH  = 32768,
   parameter int STACK_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_opcode,
   input  logic [7:0]  req_source_char,
   input  logic [7:0]  req_in_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [7:0]  rsp_out_byte,
   input  logic [11:0] rsp_program_counter,
   output int          fail_count,
   output int          pending,
   output int          result_count,
   output int          op_count,
   output logic        prog_idle
);

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  out_byte;
      logic [11:0] pc;
   } machine_result_type;

   // shadow of the machine state
   rlbf_pkg::op_kind_type ops      [PROG_DEPTH];
   logic [7:0]            op_reps  [PROG_DEPTH];
   logic [7:0]            cells    [TAPE_DEPTH];
   int                    loop_ret [STACK_DEPTH];
   int                    prog_len, pc_now, dp, loop_level, reps_left;
   bit                    halted;
   int                    fails, results;
   machine_result_type    expected_q[$];

   initial begin
      for (int i = 0; i < TAPE_DEPTH; i++) cells[i] = 8'd0;
      prog_len = 0; pc_now = 0; dp = 0; loop_level = 0; reps_left = 0;
      halted = 0; fails = 0; results = 0;
      fail_count = 0; pending = 0; result_count = 0; op_count = 0;
      prog_idle = 1'b1;
   end

   // append one source character
   task automatic load_char(input logic [7:0] c, output logic [2:0] st);
      rlbf_pkg::op_kind_type k;
      bit                    is_cmd;
      is_cmd = 1'b1;
      k = rlbf_pkg::K_INC;
      case (c)
         "+":     k = rlbf_pkg::K_INC;
         "-":     k = rlbf_pkg::K_DEC;
         ">":     k = rlbf_pkg::K_RIGHT;
         "<":     k = rlbf_pkg::K_LEFT;
         ".":     k = rlbf_pkg::K_WRITE;
         ",":     k = rlbf_pkg::K_READ;
         "[":     k = rlbf_pkg::K_OPEN;
         "]":     k = rlbf_pkg::K_CLOSE;
         default: is_cmd = 1'b0;
      endcase
      st = rlbf_pkg::ST_LOADED;
      if (is_cmd) begin
         if (k != rlbf_pkg::K_OPEN && k != rlbf_pkg::K_CLOSE && prog_len > 0 &&
             ops[prog_len-1] == k && op_reps[prog_len-1] != rlbf_pkg::MAX_COUNT) begin
            op_reps[prog_len-1] = op_reps[prog_len-1] + 8'd1;
         end else if (prog_len >= PROG_DEPTH) begin
            st = rlbf_pkg::ST_OVERFLOW;
         end else begin
            ops[prog_len] = k;
            op_reps[prog_len] = 8'd1;
            prog_len++;
         end
      end
   endtask

   // execute one stored op
   task automatic run_op(input logic [7:0] ib, output logic [2:0] st,
                         output logic [7:0] ob);
      logic [7:0] cur_val, reps;
      int         depth, p;
      ob = 8'd0;
      st = rlbf_pkg::ST_EXECUTED;
      if (halted || pc_now >= prog_len) begin
         st = rlbf_pkg::ST_HALTED;
      end else begin
         cur_val = cells[dp];
         reps = op_reps[pc_now];
         case (ops[pc_now])
            rlbf_pkg::K_INC: begin
               cells[dp] = cur_val + reps; pc_now++;
            end
            rlbf_pkg::K_DEC: begin
               cells[dp] = cur_val - reps; pc_now++;
            end
            rlbf_pkg::K_RIGHT: begin
               dp = (dp + reps) % TAPE_DEPTH; pc_now++;
            end
            rlbf_pkg::K_LEFT: begin
               dp = (dp + TAPE_DEPTH - reps % TAPE_DEPTH) % TAPE_DEPTH; pc_now++;
            end
            rlbf_pkg::K_WRITE, rlbf_pkg::K_READ: begin
               if (reps_left == 0) reps_left = reps;
               reps_left--;
               if (reps_left == 0) pc_now++;
               if (ops[pc_now - (reps_left == 0)] == rlbf_pkg::K_WRITE) begin
                  ob = cur_val; st = rlbf_pkg::ST_WROTE;
               end else begin
                  cells[dp] = ib; st = rlbf_pkg::ST_READ;
               end
            end
            rlbf_pkg::K_OPEN: begin
               if (cur_val != 0) begin
                  if (loop_level >= STACK_DEPTH) begin
                     halted = 1; st = rlbf_pkg::ST_OVERFLOW;
                  end else begin
                     loop_ret[loop_level] = pc_now; loop_level++; pc_now++;
                  end
               end else begin
                  // skip forward to the matching close
                  depth = 1;
                  p = pc_now + 1;
                  while (p < prog_len) begin
                     if (ops[p] == rlbf_pkg::K_OPEN) depth++;
                     else if (ops[p] == rlbf_pkg::K_CLOSE) depth--;
                     if (depth == 0) break;
                     p++;
                  end
                  pc_now = (p < prog_len) ? p + 1 : prog_len;
               end
            end
            default: begin
               if (loop_level == 0) begin
                  halted = 1; st = rlbf_pkg::ST_UNMATCH;
               end else if (cur_val != 0) begin
                  pc_now = loop_ret[loop_level-1] + 1;
               end else begin
                  loop_level--; pc_now++;
               end
            end
         endcase
      end
   endtask

   // watch both channels; results are checked before the new request is queued
   always @(posedge clock) begin
      machine_result_type got, want;
      logic [2:0]         st;
      logic [7:0]         ob;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_out_byte, rsp_program_counter};
            results++;
            if (expected_q.size() == 0) begin
               if (fails < 10)
                  $display("%0t: result with none expected: st=%0d byte=%0d pc=%0d",
                           $realtime, got.status, got.out_byte, got.pc);
               fails++;
            end else begin
               want = expected_q.pop_front();
               if (got.status != want.status || got.out_byte != want.out_byte ||
                   got.pc != want.pc) begin
                  if (fails < 10)
                     $display("%0t: mismatch st %0d/%0d byte %0d/%0d pc %0d/%0d (exp/act)",
                              $realtime, want.status, got.status, want.out_byte,
                              got.out_byte, want.pc, got.pc);
                  fails++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            ob = 8'd0;
            if (req_opcode == rlbf_pkg::REQ_APPEND) load_char(req_source_char, st);
            else run_op(req_in_byte, st, ob);
            want.status = st;
            want.out_byte = ob;
            want.pc = pc_now[11:0];
            expected_q.push_back(want);
         end
      end
      fail_count   <= fails;
      pending      <= expected_q.size();
      result_count <= results;
      op_count     <= prog_len;
      prog_idle    <= halted || pc_now >= prog_len;
   end

endmodule

/* bench/run_length_bf_machine_tb.sv */
`timescale 1ns / 1ps

module run_length_bf_machine_tb;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int RANDOM_ITEMS = 1250;
   localparam int STACK_N = 64;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_opcode = rlbf_pkg::REQ_APPEND;
   logic [7:0]  req_source_char = 8'd0;
   logic [7:0]  req_in_byte = 8'd0;
   logic        rsp_stall = 1'b0;
   logic        req_stall, rsp_valid;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_out_byte;
   logic [11:0] rsp_program_counter;

   int fail_count, pending, result_count, op_count;
   logic prog_idle;
   int sent = 0;
   int cycles = 0;
   int send_gap_pct = 31;
   int stall_pct = 74;
   string ending;

   run_length_bf_machine uut (.*);

   run_length_bf_machine_checker chk (.*);

   always #10 clock = ~clock;

   // receiver back-pressure and run limit
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // one transaction on the request channel
   task automatic send(input logic op, input logic [7:0] ch);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_source_char <= ch;
      req_in_byte     <= 8'($urandom);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      // idling profile follows progress through the run
      if (sent == 420) begin
         send_gap_pct = 74; stall_pct = 31;
      end else if (sent == 840) begin
         send_gap_pct = 0; stall_pct = 0;
      end
   endtask

   task automatic load_text(input string s);
      for (int i = 0; i < s.len(); i++) send(rlbf_pkg::REQ_APPEND, s[i]);
   endtask

   // step until the program runs out or cap steps are sent, at least once
   task automatic run_out(input int cap);
      int n;
      n = 0;
      do begin
         send(rlbf_pkg::REQ_STEP, 8'd0);
         n++;
      end while (!prog_idle && n < cap);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // random well-formed snippet; loops always count their cell down
   function automatic string rand_snippet();
      string s, sym;
      int    k;
      s = "";
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               sym = "+-<>.,";
               k = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 300)
                                                : $urandom_range(1, 4);
               repeat (k) s = {s, string'(sym[$urandom_range(0, 5)])};
            end
            6, 7: begin
               sym = "+-.";
               k = $urandom_range(1, 3);
               s = {s, "[-"};
               repeat (k) s = {s, ">"};
               repeat ($urandom_range(1, 3)) s = {s, string'(sym[$urandom_range(0, 2)])};
               repeat (k) s = {s, "<"};
               s = {s, "]"};
            end
            8: s = {s, "[-]"};
            default: begin
               // random byte noise, brackets excluded
               k = $urandom_range(0, 255);
               if (k == "[" || k == "]") k = 8'hDB;
               s = {s, string'(8'(k))};
            end
         endcase
      end
      return s;
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: noise, empty program, merge limit, repeats, wraps, skip
      send(rlbf_pkg::REQ_APPEND, "a");
      send(rlbf_pkg::REQ_APPEND, 8'hFF);
      send(rlbf_pkg::REQ_STEP, 8'd0);
      repeat (300) send(rlbf_pkg::REQ_APPEND, "+");
      run_out(10);
      load_text("<..>,,,.[-<]>.");
      run_out(20);
      load_text("[[+]>]-.");
      run_out(20);

      // random snippets, each run out before the next
      while (sent < RANDOM_ITEMS - 250) begin
         load_text(rand_snippet());
         run_out(1500);
      end

      // hold off until the machine has answered everything
      drain();

      case ($urandom_range(0, 2))
         0: begin
            ending = "unmatched close";
            load_text("[-]["); run_out(600);
            load_text("]"); run_out(5);
         end
         1: begin
            ending = "return stack overflow";
            load_text("[-]+"); run_out(600);
            repeat (STACK_N + 1) send(rlbf_pkg::REQ_APPEND, "[");
            run_out(200);
         end
         default: begin
            ending = "open bracket with no match";
            load_text("[-]"); run_out(600);
            send(rlbf_pkg::REQ_APPEND, "[");
         end
      endcase

      // a few more steps and appends after the ending
      run_out(3);
      load_text("+->,");
      send(rlbf_pkg::REQ_STEP, 8'd0);
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("%0d requests, %0d results checked, %0d stored ops, ending: %s",
               sent, result_count, op_count, ending);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
